### hdl/bba_pkg.sv
// Package for the bitmap block allocator.
// Holds parameter defaults, field widths, status codes and the sequencer state type.
// Depends on nothing.
package bba_pkg;

    localparam int INODE_BITS_DEFAULT = 4096;
    localparam int DATA_BITS_DEFAULT  = 32768;
    localparam int WORD_BITS_DEFAULT  = 32;

    localparam int INDEX_W = 15;
    localparam int STATUS_W = 2;
    localparam int COUNT_W = 16;

    localparam logic [COUNT_W-1:0] DATA_BLOCK_COUNT_RESET = 16'd31734;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_MARK  = 1'b1;

    localparam logic POOL_INODE = 1'b0;
    localparam logic POOL_DATA  = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_DIV,
        S_READ,
        S_CHECK,
        S_RESP
    } bba_state_t;

endpackage

### hdl/bba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for both allocation bitmaps; depends on nothing.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/bba_clear_find.sv
// Finds the lowest-index clear bit of one bitmap word, index 0 being the MSB.
// Depends on nothing.
module bba_clear_find #(
    parameter int WORD_BITS = 32,
    parameter int OFFW = $clog2(WORD_BITS)
) (
    input  logic [WORD_BITS-1:0] word,
    output logic                 found,
    output logic [OFFW-1:0]      offset
);

    always_comb
    begin
        found  = 1'b0;
        offset = '0;
        for (int p = 0; p < WORD_BITS; p++)
        begin
            if (!word[p])
            begin
                found  = 1'b1;
                offset = OFFW'(WORD_BITS - 1 - p);
            end
        end
    end

endmodule

### hdl/bba_index_div.sv
// Splits a bit index into word number and bit offset by WORD_BITS.
// Shift and mask for a power of two, otherwise a reciprocal multiplication followed by
// a registered multiply-subtract. Uses bba_pkg.
module bba_index_div #(
    parameter int WORD_BITS = 32,
    parameter int OFFW = $clog2(WORD_BITS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bba_pkg::INDEX_W-1:0] dividend,
    output logic                        done,
    output logic [bba_pkg::INDEX_W-1:0] quotient,
    output logic [OFFW-1:0]             remainder
);

    import bba_pkg::*;

    localparam bit IS_POW2 = (WORD_BITS & (WORD_BITS - 1)) == 0;
    localparam int SHIFT   = INDEX_W + OFFW;
    localparam int RW      = INDEX_W + 2;
    localparam int PW      = INDEX_W + RW;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << SHIFT) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_VAL);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [INDEX_W-1:0] num_reg, num_next;
    logic [INDEX_W-1:0] quo_reg, quo_next;
    logic [OFFW-1:0]    rem_reg, rem_next;
    logic [PW-1:0]      product;
    logic [INDEX_W-1:0] back;

    assign product = PW'(dividend) * PW'(RECIP);
    assign back    = INDEX_W'(quo_reg * INDEX_W'(WORD_BITS));

    always_comb
    begin
        busy_next = 1'b0;
        done_next = 1'b0;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            num_next = dividend;
            if (IS_POW2)
            begin
                quo_next  = dividend >> OFFW;
                rem_next  = dividend[OFFW-1:0];
                done_next = 1'b1;
            end
            else
            begin
                quo_next  = INDEX_W'(product >> SHIFT);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = OFFW'(num_reg - back);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### hdl/bitmap_block_allocator.sv
// Top level of the bitmap block allocator: sequencer, hint pointers and used count.
// Instantiates bba_ram, bba_clear_find and bba_index_div; uses bba_pkg.
//
// Usage: an input word (opcode, pool, bit_index) is taken on in_valid with in_stall low.
// Allocate returns the lowest clear index of the chosen pool and sets it; mark sets
// bit_index. One result word (granted_index, status) is produced per input word.
// The block works on one word at a time and holds in_stall high until it is done.
// Path from the accepting edge to out_valid: an in-range mark passes S_START, S_DIV
// (waiting for the divider), S_READ, S_CHECK and S_RESP; an allocate passes S_START,
// then S_READ and S_CHECK for each bitmap word read, then S_RESP. A per-pool hint
// pointer skips words already known full, so a typical allocation reads one word; one
// refused at S_START reads no word. in_stall falls as the result is registered, so a
// new word is taken only after the previous result is registered.
// After reset both bitmaps are cleared, one word per cycle over the larger word
// count; in_stall stays high meanwhile.
// The result sits in an output register; when out_stall holds it, the next input
// word is still taken and processed, and waits only for the output register.
// cfg_we writes data_block_count at any time.
module bitmap_block_allocator #(
    parameter int INODE_BITS = bba_pkg::INODE_BITS_DEFAULT,
    parameter int DATA_BITS  = bba_pkg::DATA_BITS_DEFAULT,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bba_pkg::COUNT_W-1:0]  cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         opcode,
    input  logic                         pool,
    input  logic [bba_pkg::INDEX_W-1:0]  bit_index,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bba_pkg::INDEX_W-1:0]  granted_index,
    output logic [bba_pkg::STATUS_W-1:0] status
);

    import bba_pkg::*;

    localparam int INODE_WORDS = (INODE_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int DATA_WORDS  = (DATA_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int MAX_WORDS   = (INODE_WORDS > DATA_WORDS) ? INODE_WORDS : DATA_WORDS;
    localparam int IAW  = (INODE_WORDS > 1) ? $clog2(INODE_WORDS) : 1;
    localparam int DAW  = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
    localparam int HW   = $clog2(MAX_WORDS + 1);
    localparam int IHW  = $clog2(INODE_WORDS + 1);
    localparam int DHW  = $clog2(DATA_WORDS + 1);
    localparam int OFFW = $clog2(WORD_BITS);
    localparam int FW_A = $clog2(MAX_WORDS * WORD_BITS + 1);
    localparam int FW   = (FW_A > INDEX_W + 1) ? FW_A : INDEX_W + 1;
    localparam logic [WORD_BITS-1:0] MSB_ONE = {1'b1, {(WORD_BITS - 1){1'b0}}};

    bba_state_t state_reg, state_next;

    logic [COUNT_W-1:0]  data_block_count_reg;
    logic [COUNT_W-1:0]  used_reg, used_next;
    logic [IHW-1:0]      inode_hint_reg, inode_hint_next;
    logic [DHW-1:0]      data_hint_reg, data_hint_next;
    logic [HW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [HW-1:0]       cur_word_reg, cur_word_next;
    logic [OFFW-1:0]     off_reg, off_next;
    logic                opcode_reg, pool_reg;
    logic [INDEX_W-1:0]  bidx_reg;
    logic [INDEX_W-1:0]  res_index_reg, res_index_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [WORD_BITS-1:0] inode_rdata, data_rdata, rdata;
    logic [WORD_BITS-1:0] wdata;
    logic                 inode_we, data_we;
    logic [HW-1:0]        ram_addr;
    logic                 enc_found;
    logic [OFFW-1:0]      enc_off;
    logic                 div_start, div_done;
    logic [INDEX_W-1:0]   div_quo;
    logic [OFFW-1:0]      div_rem;

    logic [HW-1:0] nwords_sel, hint_sel, cur_plus_one;
    logic [FW-1:0] nbits_sel, found_idx;
    logic          range_bad, count_full, out_free, ram_we;

    assign nwords_sel   = pool_reg ? HW'(DATA_WORDS) : HW'(INODE_WORDS);
    assign nbits_sel    = pool_reg ? FW'(DATA_BITS) : FW'(INODE_BITS);
    assign hint_sel     = pool_reg ? HW'(data_hint_reg) : HW'(inode_hint_reg);
    assign cur_plus_one = HW'(cur_word_reg + 1'b1);
    assign range_bad    = FW'(bidx_reg) >= nbits_sel;
    assign count_full   = (pool_reg == POOL_DATA) && (used_reg >= data_block_count_reg);
    assign found_idx    = FW'(cur_word_reg) * FW'(WORD_BITS) + FW'(enc_off);
    assign rdata        = pool_reg ? data_rdata : inode_rdata;
    assign out_free     = !out_valid_reg || !out_stall;

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (INODE_WORDS)
    ) u_inode_ram (
        .clk   (clk),
        .we    (inode_we),
        .waddr (ram_addr[IAW-1:0]),
        .wdata (wdata),
        .raddr (ram_addr[IAW-1:0]),
        .rdata (inode_rdata)
    );

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DATA_WORDS)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (ram_addr[DAW-1:0]),
        .wdata (wdata),
        .raddr (ram_addr[DAW-1:0]),
        .rdata (data_rdata)
    );

    bba_clear_find #(
        .WORD_BITS (WORD_BITS)
    ) u_find (
        .word   (rdata),
        .found  (enc_found),
        .offset (enc_off)
    );

    bba_index_div #(
        .WORD_BITS (WORD_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (bidx_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == HW'(MAX_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (opcode_reg == OP_MARK)
                begin
                    state_next = range_bad ? S_RESP : S_DIV;
                end
                else if (count_full || (hint_sel >= nwords_sel))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if ((opcode_reg == OP_ALLOC) && !enc_found && (cur_plus_one < nwords_sel))
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        used_next       = used_reg;
        inode_hint_next = inode_hint_reg;
        data_hint_next  = data_hint_reg;
        clr_cnt_next    = clr_cnt_reg;
        cur_word_next   = cur_word_reg;
        off_next        = off_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        div_start       = 1'b0;
        ram_we          = 1'b0;
        ram_addr        = cur_word_reg;
        wdata           = rdata | (MSB_ONE >> off_reg);
        inode_we        = 1'b0;
        data_we         = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_addr     = clr_cnt_reg;
                wdata        = '0;
                inode_we     = clr_cnt_reg < HW'(INODE_WORDS);
                data_we      = clr_cnt_reg < HW'(DATA_WORDS);
                clr_cnt_next = HW'(clr_cnt_reg + 1'b1);
            end
            S_START:
            begin
                res_index_next  = '0;
                res_status_next = STATUS_OK;
                cur_word_next   = hint_sel;
                if (opcode_reg == OP_MARK)
                begin
                    if (range_bad)
                    begin
                        res_status_next = STATUS_RANGE;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
                else if (count_full || (hint_sel >= nwords_sel))
                begin
                    res_status_next = STATUS_FULL;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    cur_word_next = HW'(div_quo);
                    off_next      = div_rem;
                end
            end
            S_CHECK:
            begin
                if (opcode_reg == OP_MARK)
                begin
                    ram_we         = 1'b1;
                    res_index_next = bidx_reg;
                end
                else if (!enc_found)
                begin
                    cur_word_next = cur_plus_one;
                    if (pool_reg == POOL_DATA)
                    begin
                        data_hint_next = DHW'(cur_plus_one);
                    end
                    else
                    begin
                        inode_hint_next = IHW'(cur_plus_one);
                    end
                    if (cur_plus_one >= nwords_sel)
                    begin
                        res_status_next = STATUS_FULL;
                    end
                end
                else if (found_idx >= nbits_sel)
                begin
                    res_status_next = STATUS_FULL;
                end
                else
                begin
                    ram_we         = 1'b1;
                    wdata          = rdata | (MSB_ONE >> enc_off);
                    res_index_next = found_idx[INDEX_W-1:0];
                    if (pool_reg == POOL_DATA)
                    begin
                        used_next = COUNT_W'(used_reg + 1'b1);
                    end
                end
                inode_we = ram_we && (pool_reg == POOL_INODE);
                data_we  = ram_we && (pool_reg == POOL_DATA);
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_CLEAR;
            data_block_count_reg <= DATA_BLOCK_COUNT_RESET;
            used_reg             <= '0;
            inode_hint_reg       <= '0;
            data_hint_reg        <= '0;
            clr_cnt_reg          <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            inode_hint_reg <= inode_hint_next;
            data_hint_reg  <= data_hint_next;
            clr_cnt_reg    <= clr_cnt_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                data_block_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_word_reg   <= cur_word_next;
        off_reg        <= off_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        if ((state_reg == S_IDLE) && in_valid)
        begin
            opcode_reg <= opcode;
            pool_reg   <= pool;
            bidx_reg   <= bit_index;
        end
        if ((state_reg == S_RESP) && out_free)
        begin
            out_index_reg  <= res_index_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign in_stall      = state_reg != S_IDLE;
    assign out_valid     = out_valid_reg;
    assign granted_index = out_index_reg;
    assign status        = out_status_reg;

endmodule
